// ===== hdl/fscs_pkg.sv =====
// ----------------------------------------------------------------------------
// fscs_pkg
// shared types, constants and the control store of the credit scheduler
// ----------------------------------------------------------------------------
package fscs_pkg;

   // time width of the stored last-update time and the divider
   localparam int TIME_BITS     = 48;
   localparam int STEP_BITS     = 24;
   localparam int POOL_BITS     = 16;
   localparam int COUNT_BITS    = 16;
   localparam int STEP_OUT_BITS = 48;
   localparam int FIELD_BITS    = 48;
   localparam int REQ_DATA_BITS = 2 * FIELD_BITS;
   localparam int RSP_DATA_BITS = COUNT_BITS + STEP_OUT_BITS;
   localparam int CSR_DATA_BITS = 24;
   localparam int CSR_IDX_BITS  = 2;
   localparam int DIV_CNT_BITS  = $clog2(TIME_BITS + 1);
   localparam int PC_BITS       = 5;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [PC_BITS-1:0]       pc_type;
   typedef logic [DIV_CNT_BITS-1:0]  div_cnt_type;

   localparam logic [STEP_OUT_BITS-1:0] STEP_MAX = '1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FIXED_STEP  = 2'd0,
      CSR_POOL_CEIL   = 2'd1,
      CSR_POOL_REFILL = 2'd2
   } csr_idx_type;

   // command codes carried in req_tuser
   typedef enum logic {
      CMD_QUERY   = 1'b0,
      CMD_ADVANCE = 1'b1
   } cmd_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_ELAPSED,
      OP_DIV_STEP,
      OP_COUNT_STEP,
      OP_DIV_POOL,
      OP_LEN,
      OP_DIV_LEN,
      OP_COUNT,
      OP_CLEAR,
      OP_REFILL,
      OP_ADVANCE
   } op_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ITEM,
      COND_IS_ADVANCE,
      COND_NOT_FIRST,
      COND_BEHIND,
      COND_BELOW_STEP,
      COND_DIV_BUSY,
      COND_COUNT_FITS,
      COND_POOL_EMPTY,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ZERO,
      EMIT_RESULT
   } emit_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
      emit_type emit;
   } ctrl_word_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic item_valid;
      logic is_advance;
      logic not_first;
      logic behind;
      logic below_step;
      logic div_busy;
      logic count_fits;
      logic pool_empty;
      logic out_busy;
   } useq_status_type;

   // sequencer outputs to the datapath
   typedef struct packed {
      op_type   op;
      emit_type emit;
      logic     emit_go;
      logic     idle;
   } useq_ctl_type;

   // program addresses
   localparam pc_type ADDR_IDLE    = pc_type'(0);
   localparam pc_type ADDR_CHECK   = pc_type'(4);
   localparam pc_type ADDR_WAIT_A  = pc_type'(8);
   localparam pc_type ADDR_WAIT_B  = pc_type'(13);
   localparam pc_type ADDR_WAIT_C  = pc_type'(16);
   localparam pc_type ADDR_EMPTY   = pc_type'(18);
   localparam pc_type ADDR_REFILL  = pc_type'(19);
   localparam pc_type ADDR_OUT     = pc_type'(20);
   localparam pc_type ADDR_ADVANCE = pc_type'(21);
   localparam pc_type ADDR_ZERO    = pc_type'(22);

   function automatic ctrl_word_type cw(input op_type op, input cond_type cond,
                                        input pc_type target, input emit_type emit);
      ctrl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.emit   = emit;
      return w;
   endfunction

   // control store: one word per step
   function automatic ctrl_word_type useq_rom(input pc_type addr);
      ctrl_word_type w;
      case (addr)
         pc_type'(0):  w = cw(OP_NOP,        COND_NO_ITEM,    ADDR_IDLE,    EMIT_NONE);
         pc_type'(1):  w = cw(OP_NOP,        COND_IS_ADVANCE, ADDR_ADVANCE, EMIT_NONE);
         pc_type'(2):  w = cw(OP_NOP,        COND_NOT_FIRST,  ADDR_CHECK,   EMIT_NONE);
         pc_type'(3):  w = cw(OP_LATCH,      COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(4):  w = cw(OP_NOP,        COND_BEHIND,     ADDR_ZERO,    EMIT_NONE);
         pc_type'(5):  w = cw(OP_ELAPSED,    COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(6):  w = cw(OP_NOP,        COND_BELOW_STEP, ADDR_ZERO,    EMIT_NONE);
         pc_type'(7):  w = cw(OP_DIV_STEP,   COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(8):  w = cw(OP_NOP,        COND_DIV_BUSY,   ADDR_WAIT_A,  EMIT_NONE);
         pc_type'(9):  w = cw(OP_COUNT_STEP, COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(10): w = cw(OP_NOP,        COND_COUNT_FITS, ADDR_REFILL,  EMIT_NONE);
         pc_type'(11): w = cw(OP_NOP,        COND_POOL_EMPTY, ADDR_EMPTY,   EMIT_NONE);
         pc_type'(12): w = cw(OP_DIV_POOL,   COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(13): w = cw(OP_NOP,        COND_DIV_BUSY,   ADDR_WAIT_B,  EMIT_NONE);
         pc_type'(14): w = cw(OP_LEN,        COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(15): w = cw(OP_DIV_LEN,    COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(16): w = cw(OP_NOP,        COND_DIV_BUSY,   ADDR_WAIT_C,  EMIT_NONE);
         pc_type'(17): w = cw(OP_COUNT,      COND_ALWAYS,     ADDR_REFILL,  EMIT_NONE);
         pc_type'(18): w = cw(OP_CLEAR,      COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(19): w = cw(OP_REFILL,     COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(20): w = cw(OP_NOP,        COND_OUT_BUSY,   ADDR_OUT,     EMIT_RESULT);
         pc_type'(21): w = cw(OP_ADVANCE,    COND_NEVER,      ADDR_IDLE,    EMIT_NONE);
         pc_type'(22): w = cw(OP_NOP,        COND_OUT_BUSY,   ADDR_ZERO,    EMIT_ZERO);
         default:      w = cw(OP_NOP,        COND_ALWAYS,     ADDR_IDLE,    EMIT_NONE);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/fscs_div.sv =====
// ----------------------------------------------------------------------------
// fscs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fscs_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  fscs_pkg::time_type dividend,
   input  fscs_pkg::time_type divisor,
   output fscs_pkg::time_type quotient,
   output logic               rem_nonzero,
   output logic               busy
);
   import fscs_pkg::*;

   logic                 busy_ff, busy_in;
   div_cnt_type          cnt_ff, cnt_in;
   time_type             quo_ff, quo_in;
   time_type             rem_ff, rem_in;
   time_type             den_ff, den_in;
   logic [TIME_BITS:0]   trial;
   logic [TIME_BITS:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[TIME_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = div_cnt_type'(TIME_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_BITS-2:0], fits};
         rem_in = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
         cnt_in = cnt_ff - div_cnt_type'(1);
         if (cnt_ff == div_cnt_type'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign rem_nonzero = |rem_ff;
   assign busy        = busy_ff;

endmodule

// ===== hdl/fscs_useq.sv =====
// ----------------------------------------------------------------------------
// fscs_useq
// step counter, control store and jump logic
// ----------------------------------------------------------------------------
module fscs_useq (
   input  logic                      clock,
   input  logic                      reset,
   input  fscs_pkg::useq_status_type status,
   output fscs_pkg::useq_ctl_type    ctl
);
   import fscs_pkg::*;

   pc_type        pc_ff, pc_in;
   ctrl_word_type word;
   logic          taken;

   assign word = useq_rom(pc_ff);

   always_comb begin
      case (word.cond)
         COND_NEVER:      taken = 1'b0;
         COND_ALWAYS:     taken = 1'b1;
         COND_NO_ITEM:    taken = ~status.item_valid;
         COND_IS_ADVANCE: taken = status.is_advance;
         COND_NOT_FIRST:  taken = status.not_first;
         COND_BEHIND:     taken = status.behind;
         COND_BELOW_STEP: taken = status.below_step;
         COND_DIV_BUSY:   taken = status.div_busy;
         COND_COUNT_FITS: taken = status.count_fits;
         COND_POOL_EMPTY: taken = status.pool_empty;
         COND_OUT_BUSY:   taken = status.out_busy;
         default:         taken = 1'b0;
      endcase
   end

   always_comb begin
      ctl.op      = word.op;
      ctl.emit    = word.emit;
      ctl.emit_go = (word.emit != EMIT_NONE) && !taken;
      ctl.idle    = (pc_ff == ADDR_IDLE);
   end

   always_comb begin
      if (ctl.emit_go) begin
         pc_in = ADDR_IDLE;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + pc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ADDR_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hdl/fixed_step_credit_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_step_credit_scheduler_unit
// fixed-timestep scheduler with a credit pool, microcoded
// ----------------------------------------------------------------------------
// One item at a time. A frame query (tuser = 0) returns how many fixed update
// steps to run and the length of each; an advance item (tuser = 1) adds its
// step to the stored last-update time and returns zeros. The first query only
// latches the time and loads the credit pool from the ceiling. Timing is set
// by a small control program stepping one word per cycle and by one shared
// restoring divider that yields one quotient bit per cycle. A query with no
// step due returns zeros, a query that fits the pool runs one division by the
// step, and a query limited by the pool runs two more divisions. The next item
// is accepted once the result is parked in the output register, even if it is
// not yet taken. The configuration port is always ready and should be written
// only while no item is in flight.
module fixed_step_credit_scheduler_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: current_time_us [47:0], advance_step [95:48]
   input  logic [fscs_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // tuser: command (0 query, 1 advance)
   input  logic                                  req_tuser,
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: iteration_count [15:0], step_us [63:16]
   output logic [fscs_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fscs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [fscs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import fscs_pkg::*;

   // configuration registers
   logic [STEP_BITS-1:0]     fixed_step_ff, fixed_step_in;
   logic [POOL_BITS-1:0]     pool_ceil_ff, pool_ceil_in;
   logic [POOL_BITS-1:0]     pool_refill_ff, pool_refill_in;

   // latched transaction
   logic                     cmd_ff, cmd_in;
   time_type                 now_ff, now_in;
   time_type                 adv_ff, adv_in;

   // scheduler state
   time_type                 last_ff, last_in;
   logic [POOL_BITS-1:0]     pool_ff, pool_in;
   logic                     first_ff, first_in;

   // working registers
   time_type                 elapsed_ff, elapsed_in;
   time_type                 count_ff, count_in;
   time_type                 len_ff, len_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   useq_status_type          status;
   useq_ctl_type             ctl;

   logic [STEP_BITS-1:0]     step_eff;
   time_type                 div_quo;
   logic                     div_nz;
   logic                     div_busy;
   logic                     div_start;
   time_type                 div_den;
   time_type                 quo_up;
   logic [POOL_BITS:0]       pool_sum;
   logic [POOL_BITS-1:0]     pool_next;
   logic [STEP_OUT_BITS-1:0] step_sat;
   logic                     req_accept;

   // a zero step behaves as one microsecond
   assign step_eff   = (fixed_step_ff == '0) ? STEP_BITS'(1) : fixed_step_ff;
   assign req_tready = ctl.idle;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   // divide rounding up
   assign quo_up = div_quo + time_type'(div_nz);

   // count never exceeds the pool here, so its low bits are the whole value
   assign pool_sum  = {1'b0, pool_ff} - {1'b0, count_ff[POOL_BITS-1:0]}
                    + {1'b0, pool_refill_ff};
   assign pool_next = (pool_sum < {1'b0, pool_ceil_ff}) ? pool_sum[POOL_BITS-1:0]
                                                        : pool_ceil_ff;

   // step length saturates at the output width
   assign step_sat = (64'(len_ff) > 64'(STEP_MAX)) ? STEP_MAX : STEP_OUT_BITS'(len_ff);

   // divider operand select
   always_comb begin
      case (ctl.op)
         OP_DIV_POOL: div_den = time_type'(pool_ff);
         OP_DIV_LEN:  div_den = len_ff;
         default:     div_den = time_type'(step_eff);
      endcase
   end

   assign div_start = (ctl.op == OP_DIV_STEP) || (ctl.op == OP_DIV_POOL)
                   || (ctl.op == OP_DIV_LEN);

   fscs_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (elapsed_ff),
      .divisor     (div_den),
      .quotient    (div_quo),
      .rem_nonzero (div_nz),
      .busy        (div_busy)
   );

   // flags for the jump logic
   always_comb begin
      status.item_valid = req_tvalid;
      status.is_advance = (cmd_ff == CMD_ADVANCE);
      status.not_first  = ~first_ff;
      status.behind     = now_ff < last_ff;
      status.below_step = elapsed_ff < time_type'(step_eff);
      status.div_busy   = div_busy;
      status.count_fits = count_ff <= time_type'(pool_ff);
      status.pool_empty = (pool_ff == '0);
      status.out_busy   = rsp_valid_ff & ~rsp_tready;
   end

   fscs_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   // register writes
   always_comb begin
      fixed_step_in  = fixed_step_ff;
      pool_ceil_in   = pool_ceil_ff;
      pool_refill_in = pool_refill_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIXED_STEP:  fixed_step_in  = csr_wdata;
            CSR_POOL_CEIL:   pool_ceil_in   = csr_wdata[POOL_BITS-1:0];
            CSR_POOL_REFILL: pool_refill_in = csr_wdata[POOL_BITS-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // datapath driven by the current control word
   always_comb begin
      cmd_in     = cmd_ff;
      now_in     = now_ff;
      adv_in     = adv_ff;
      last_in    = last_ff;
      pool_in    = pool_ff;
      first_in   = first_ff;
      elapsed_in = elapsed_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      if (req_accept) begin
         cmd_in = req_tuser;
         now_in = time_type'(req_tdata[FIELD_BITS-1:0]);
         adv_in = time_type'(req_tdata[REQ_DATA_BITS-1:FIELD_BITS]);
      end
      case (ctl.op)
         OP_LATCH: begin
            // first query: take the time, fill the pool
            last_in  = now_ff;
            pool_in  = pool_ceil_ff;
            first_in = 1'b0;
         end
         OP_ELAPSED:    elapsed_in = now_ff - last_ff;
         OP_COUNT_STEP: begin
            count_in = quo_up;
            len_in   = time_type'(step_eff);
         end
         OP_LEN:        len_in   = quo_up;
         OP_COUNT:      count_in = quo_up;
         OP_CLEAR: begin
            // empty pool with steps due
            count_in = '0;
            len_in   = '0;
         end
         OP_REFILL:     pool_in = pool_next;
         OP_ADVANCE:    last_in = last_ff + adv_ff;
         default: ;
      endcase
   end

   // output register, refilled as it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (ctl.emit_go) begin
         rsp_valid_in = 1'b1;
         case (ctl.emit)
            EMIT_RESULT: rsp_data_in = {step_sat, count_ff[COUNT_BITS-1:0]};
            default:     rsp_data_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_step_ff  <= STEP_BITS'(16666);
         pool_ceil_ff   <= POOL_BITS'(200);
         pool_refill_ff <= POOL_BITS'(10);
         last_ff        <= '0;
         pool_ff        <= '0;
         first_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fixed_step_ff  <= fixed_step_in;
         pool_ceil_ff   <= pool_ceil_in;
         pool_refill_ff <= pool_refill_in;
         last_ff        <= last_in;
         pool_ff        <= pool_in;
         first_ff       <= first_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      adv_ff      <= adv_in;
      elapsed_ff  <= elapsed_in;
      count_ff    <= count_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // a result never overwrites one that is still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit_go |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result emitted over a pending result");

   // an accepted transaction takes the sequencer out of idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("sequencer stayed idle after accept");

   // a nonzero step count always comes with a nonzero step length
   a_count_has_len: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit_go && ctl.emit == EMIT_RESULT && count_ff[COUNT_BITS-1:0] != '0)
      |-> len_ff != '0)
      else $error("step count without step length");

endmodule
